FILE: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, sizes and helpers for the bounded deque with value removal.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CAPACITY      = 64;
    localparam int WORD_BITS     = 32;
    localparam int ADDR_BITS     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_BITS  = 7;
    localparam int BAL_BITS      = CNT_BITS + 2;

    typedef logic [WORD_BITS-1:0]    t_word;
    typedef logic [ADDR_BITS-1:0]    t_addr;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [OUT_CNT_BITS-1:0] t_ocnt;
    typedef logic [BAL_BITS-1:0]     t_bal;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_DROP_FRONT = 2'd2,
        ACT_REMOVE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY_POP = 2'd1,
        STS_FULL_PUSH = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // slot that lies offset entries after the front
    function automatic t_addr slot_of(input t_addr front, input t_cnt offset);
        logic [CNT_BITS:0] sum;
        sum = (CNT_BITS+1)'(front) + (CNT_BITS+1)'(offset);
        if (sum >= (CNT_BITS+1)'(CAPACITY)) begin
            sum = sum - (CNT_BITS+1)'(CAPACITY);
        end
        return ADDR_BITS'(sum);
    endfunction

endpackage

FILE: rtl/core/bounded_deque_with_value_removal.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal
// Fixed-capacity deque of words in a circular buffer with push front, push
// back, pop front and remove-all-matching with in-place compaction.
//
//  channel   dir  signals                                       handshake
//  request   in   i_action, i_value                             start & !busy
//  result    out  o_count, o_is_empty, o_status, o_removed_count o_done
//
//  push and pop: result beat on the cycle after acceptance, busy
//  stays low so a new beat may follow at once.
//  remove: busy from the cycle after acceptance through the scan; one entry
//  read per cycle from the single read port, compare and compacting write
//  in the following cycle; result beat as busy falls.
//  reset: synchronous, clears front, count and control; memory is not cleared.
//  the receiver cannot stall; each result beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic signed [31:0] i_value,
    output logic        o_done,
    output logic [6:0]  o_count,
    output logic        o_is_empty,
    output logic [1:0]  o_status,
    output logic [6:0]  o_removed_count
);

    bdq_pkg::t_state  r_state, n_state;
    bdq_pkg::t_addr   r_front, n_front;
    bdq_pkg::t_cnt    r_total, n_total;
    bdq_pkg::t_cnt    r_rd, n_rd;
    bdq_pkg::t_cnt    r_kept, n_kept;
    bdq_pkg::t_cnt    r_removed, n_removed;
    logic             r_chk, n_chk;
    bdq_pkg::t_word   r_word, n_word;
    logic             r_done, n_done;
    bdq_pkg::t_ocnt   r_count, n_count;
    logic             r_empty, n_empty;
    bdq_pkg::t_status r_status, n_status;
    bdq_pkg::t_ocnt   r_rmcnt, n_rmcnt;

    logic             accept;
    logic             scan_end;
    logic             match;
    logic             mem_we;
    bdq_pkg::t_addr   mem_waddr;
    bdq_pkg::t_word   mem_wdata;
    bdq_pkg::t_addr   mem_raddr;
    bdq_pkg::t_word   mem_rdata;
    bdq_pkg::t_word   in_word;
    bdq_pkg::t_action act;

    assign accept   = start && !busy;
    assign in_word  = bdq_pkg::t_word'($unsigned(i_value));
    assign act      = bdq_pkg::t_action'(i_action);
    assign scan_end = (r_rd == r_total) && !r_chk;
    assign match    = r_chk && (mem_rdata == r_word);

    bdq_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (accept && act == bdq_pkg::ACT_REMOVE) begin
                    n_state = bdq_pkg::ST_SCAN;
                end
            end
            bdq_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = bdq_pkg::ST_IDLE;
                end
            end
            default: n_state = bdq_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        busy      = (r_state == bdq_pkg::ST_SCAN);
        n_front   = r_front;
        n_total   = r_total;
        n_rd      = r_rd;
        n_kept    = r_kept;
        n_removed = r_removed;
        n_chk     = 1'b0;
        n_word    = r_word;
        n_done    = 1'b0;
        n_count   = r_count;
        n_empty   = r_empty;
        n_status  = r_status;
        n_rmcnt   = r_rmcnt;
        mem_we    = 1'b0;
        mem_waddr = bdq_pkg::slot_of(r_front, r_kept);
        mem_wdata = mem_rdata;
        mem_raddr = bdq_pkg::slot_of(r_front, r_rd);

        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_status = bdq_pkg::STS_OK;
                    n_rmcnt  = '0;
                    unique case (act)
                        bdq_pkg::ACT_PUSH_FRONT: begin
                            if (r_total >= bdq_pkg::t_cnt'(bdq_pkg::CAPACITY)) begin
                                n_status = bdq_pkg::STS_FULL_PUSH;
                            end else begin
                                n_front   = (r_front == '0)
                                          ? bdq_pkg::t_addr'(bdq_pkg::CAPACITY - 1)
                                          : r_front - 1'b1;
                                n_total   = r_total + 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = n_front;
                                mem_wdata = in_word;
                            end
                        end
                        bdq_pkg::ACT_PUSH_REAR: begin
                            if (r_total >= bdq_pkg::t_cnt'(bdq_pkg::CAPACITY)) begin
                                n_status = bdq_pkg::STS_FULL_PUSH;
                            end else begin
                                n_total   = r_total + 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = bdq_pkg::slot_of(r_front, r_total);
                                mem_wdata = in_word;
                            end
                        end
                        bdq_pkg::ACT_DROP_FRONT: begin
                            if (r_total == '0) begin
                                n_status = bdq_pkg::STS_EMPTY_POP;
                            end else begin
                                n_front = bdq_pkg::slot_of(r_front, bdq_pkg::t_cnt'(1));
                                n_total = r_total - 1'b1;
                            end
                        end
                        default: begin
                            n_word    = in_word;
                            n_rd      = '0;
                            n_kept    = '0;
                            n_removed = '0;
                        end
                    endcase
                    if (act != bdq_pkg::ACT_REMOVE) begin
                        n_done  = 1'b1;
                        n_count = bdq_pkg::t_ocnt'(n_total);
                        n_empty = (n_total == '0);
                    end
                end
            end
            bdq_pkg::ST_SCAN: begin
                if (r_rd != r_total) begin
                    n_rd  = r_rd + 1'b1;
                    n_chk = 1'b1;
                end
                if (r_chk) begin
                    if (match) begin
                        n_removed = r_removed + 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_kept = r_kept + 1'b1;
                    end
                end
                if (scan_end) begin
                    n_total  = r_kept;
                    n_done   = 1'b1;
                    n_count  = bdq_pkg::t_ocnt'(r_kept);
                    n_empty  = (r_kept == '0);
                    n_status = bdq_pkg::STS_OK;
                    n_rmcnt  = bdq_pkg::t_ocnt'(r_removed);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::ST_IDLE;
            r_front <= '0;
            r_total <= '0;
            r_chk   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_total <= n_total;
            r_chk   <= n_chk;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_kept    <= n_kept;
        r_removed <= n_removed;
        r_word    <= n_word;
        r_count   <= n_count;
        r_empty   <= n_empty;
        r_status  <= n_status;
        r_rmcnt   <= n_rmcnt;
    end

    assign o_done          = r_done;
    assign o_count         = r_count;
    assign o_is_empty      = r_empty;
    assign o_status        = r_status;
    assign o_removed_count = r_rmcnt;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= bdq_pkg::t_cnt'(bdq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_push_pop_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && act != bdq_pkg::ACT_REMOVE) |=> o_done)
        else $error("missing result beat after push or pop");

    a_scan_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdq_pkg::ST_SCAN) |->
        (bdq_pkg::t_bal'(r_kept) + bdq_pkg::t_bal'(r_removed) + bdq_pkg::t_bal'(r_chk)
            == bdq_pkg::t_bal'(r_rd)))
        else $error("scan bookkeeping out of balance");

    a_scan_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == bdq_pkg::ST_SCAN && r_state == bdq_pkg::ST_SCAN) |-> !o_done)
        else $error("result beat in the middle of a scan");

endmodule

FILE: rtl/core/bdq_store.sv
// ----------------------------------------------------------------------------
// bdq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store (
    input  logic            i_clk,
    input  logic            i_we,
    input  bdq_pkg::t_addr  i_waddr,
    input  bdq_pkg::t_word  i_wdata,
    input  bdq_pkg::t_addr  i_raddr,
    output bdq_pkg::t_word  o_rdata
);

    bdq_pkg::t_word mem [bdq_pkg::CAPACITY];
    bdq_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/bounded_deque_with_value_removal_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal_test
// Self-checking testbench for the bounded deque. Requests go in over the
// start/busy handshake. A shadow deque in the testbench works out the count,
// empty flag, status and removed count of each accepted request. Every
// o_done beat is compared with the oldest outcome still waiting. Directed
// tests cover empty, full, wraparound and removal of the last entry.
// Randomized segments then fill, drain and mix at three sender idle rates.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int SHOW_MAX   = 10;

    typedef struct packed {
        bdq_pkg::t_ocnt   count;
        logic             is_empty;
        bdq_pkg::t_status status;
        bdq_pkg::t_ocnt   removed;
    } t_outcome;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = bdq_pkg::ACT_PUSH_FRONT;
    logic signed [31:0] i_value = '0;
    logic               o_done;
    logic [6:0]         o_count;
    logic               o_is_empty;
    logic [1:0]         o_status;
    logic [6:0]         o_removed_count;

    t_outcome       outcome_q[$];
    bdq_pkg::t_word shadow_store[bdq_pkg::CAPACITY];
    int             shadow_front;
    int             shadow_total;
    bdq_pkg::t_word value_pool[6];

    int idle_pct;
    int mismatches;
    int idle_cycles;
    int beats_sent;
    int removals_sent;
    int entries_removed;
    int full_hits;
    int empty_hits;

    bounded_deque_with_value_removal dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status),
        .o_removed_count (o_removed_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_outcome deque_apply(input bdq_pkg::t_action act,
                                             input bdq_pkg::t_word val);
        t_outcome       res;
        int             kept;
        int             rd;
        bdq_pkg::t_word e;
        res.status  = bdq_pkg::STS_OK;
        res.removed = '0;
        case (act)
            bdq_pkg::ACT_PUSH_FRONT: begin
                if (shadow_total >= bdq_pkg::CAPACITY) begin
                    res.status = bdq_pkg::STS_FULL_PUSH;
                end else begin
                    shadow_front = (shadow_front + bdq_pkg::CAPACITY - 1) % bdq_pkg::CAPACITY;
                    shadow_store[shadow_front] = val;
                    shadow_total++;
                end
            end
            bdq_pkg::ACT_PUSH_REAR: begin
                if (shadow_total >= bdq_pkg::CAPACITY) begin
                    res.status = bdq_pkg::STS_FULL_PUSH;
                end else begin
                    shadow_store[(shadow_front + shadow_total) % bdq_pkg::CAPACITY] = val;
                    shadow_total++;
                end
            end
            bdq_pkg::ACT_DROP_FRONT: begin
                if (shadow_total == 0) begin
                    res.status = bdq_pkg::STS_EMPTY_POP;
                end else begin
                    shadow_front = (shadow_front + 1) % bdq_pkg::CAPACITY;
                    shadow_total--;
                end
            end
            default: begin
                kept = 0;
                for (rd = 0; rd < shadow_total; rd++) begin
                    e = shadow_store[(shadow_front + rd) % bdq_pkg::CAPACITY];
                    if (e == val) begin
                        res.removed++;
                    end else begin
                        shadow_store[(shadow_front + kept) % bdq_pkg::CAPACITY] = e;
                        kept++;
                    end
                end
                shadow_total = kept;
            end
        endcase
        res.count    = bdq_pkg::t_ocnt'(shadow_total);
        res.is_empty = (shadow_total == 0);
        return res;
    endfunction

    // one request beat; start is left high so the next beat can follow at once
    task automatic send_request(input bdq_pkg::t_action act, input bdq_pkg::t_word val);
        t_outcome res;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = deque_apply(act, val);
        outcome_q.insert(outcome_q.size(), res);
        beats_sent++;
        if (act == bdq_pkg::ACT_REMOVE) begin
            removals_sent++;
            entries_removed += res.removed;
        end
        if (res.status == bdq_pkg::STS_FULL_PUSH) full_hits++;
        if (res.status == bdq_pkg::STS_EMPTY_POP) empty_hits++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX) begin
                        $display("unexpected beat: count %0d empty %0d status %0d removed %0d",
                                 o_count, o_is_empty, o_status, o_removed_count);
                    end
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    if (o_count !== want.count || o_is_empty !== want.is_empty ||
                        o_status !== want.status || o_removed_count !== want.removed) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $display("expected count %0d empty %0d status %0d removed %0d",
                                     want.count, want.is_empty, want.status, want.removed);
                            $display("actual   count %0d empty %0d status %0d removed %0d",
                                     o_count, o_is_empty, o_status, o_removed_count);
                        end
                    end
                end
            end
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", outcome_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_empty_requests();
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h5555_5555);
    endtask

    task automatic test_value_extremes();
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
        // match at the last entry too
        send_request(bdq_pkg::ACT_REMOVE, 32'h7FFF_FFFF);
        send_request(bdq_pkg::ACT_REMOVE, 32'h1234_5678);
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'hAAAA_AAAA);
        send_request(bdq_pkg::ACT_REMOVE, 32'hAAAA_AAAA);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::ACT_REMOVE, 32'h8000_0000);
    endtask

    task automatic test_full_and_wrap();
        int k;
        for (k = 0; k < bdq_pkg::CAPACITY - 1; k++) begin
            if (k % 2 == 0) begin
                send_request(bdq_pkg::ACT_PUSH_FRONT, 32'hC0DE_0001);
            end else begin
                send_request(bdq_pkg::ACT_PUSH_REAR, $urandom());
            end
        end
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'h0BAD_F00D);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'h0000_0002);
        // full store, only the last entry matches
        send_request(bdq_pkg::ACT_REMOVE, 32'h0BAD_F00D);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'hC0DE_0001);
        send_request(bdq_pkg::ACT_PUSH_REAR, 32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_REMOVE, 32'hC0DE_0001);
        while (shadow_total > 1) send_request(bdq_pkg::ACT_DROP_FRONT, $urandom());
        send_request(bdq_pkg::ACT_REMOVE, shadow_store[shadow_front]);
        send_request(bdq_pkg::ACT_DROP_FRONT, 32'h0000_0000);
    endtask

    task automatic test_random_mix(input int n_beats);
        t_mix           mix;
        int             seg_left;
        int             sent;
        int             roll;
        int             k;
        bdq_pkg::t_word val;
        seg_left = 0;
        mix      = MIX_EVEN;
        for (sent = 0; sent < n_beats; sent++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                mix = t_mix'($urandom_range(0, 2));
                for (k = 0; k < 6; k++) begin
                    case ($urandom_range(0, 3))
                        0: value_pool[k] = 32'h8000_0000;
                        1: value_pool[k] = 32'h7FFF_FFFF;
                        default: value_pool[k] = $urandom();
                    endcase
                end
            end
            seg_left--;
            if ($urandom_range(0, 1) == 0) begin
                val = value_pool[$urandom_range(0, 5)];
            end else begin
                val = $urandom();
            end
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  roll = (roll < 80) ? 0 : (roll < 88) ? 1 : 2;
                MIX_DRAIN: roll = (roll < 15) ? 0 : (roll < 85) ? 1 : 2;
                default:   roll = (roll < 40) ? 0 : (roll < 70) ? 1 : 2;
            endcase
            if (roll == 0) begin
                send_request($urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_FRONT
                                                  : bdq_pkg::ACT_PUSH_REAR, val);
            end else if (roll == 1) begin
                send_request(bdq_pkg::ACT_DROP_FRONT, val);
            end else begin
                if (shadow_total > 0 && $urandom_range(0, 99) < 60) begin
                    val = shadow_store[(shadow_front + $urandom_range(0, shadow_total - 1))
                                       % bdq_pkg::CAPACITY];
                end
                send_request(bdq_pkg::ACT_REMOVE, val);
            end
        end
    endtask

    initial begin
        mismatches      = 0;
        idle_cycles     = 0;
        beats_sent      = 0;
        removals_sent   = 0;
        entries_removed = 0;
        full_hits       = 0;
        empty_hits      = 0;
        shadow_front    = 0;
        shadow_total    = 0;
        idle_pct        = 14;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_value_extremes();
        wait_drained();
        test_full_and_wrap();
        wait_drained();

        test_random_mix(160);
        wait_drained();
        idle_pct = 50;
        test_random_mix(160);
        wait_drained();
        idle_pct = 0;
        test_random_mix(160);
        wait_drained();
        repeat (bdq_pkg::CAPACITY + 8) @(posedge i_clk);

        $display("sent %0d request beats, %0d removals deleting %0d entries",
                 beats_sent, removals_sent, entries_removed);
        $display("full pushes seen %0d, empty pops seen %0d", full_hits, empty_hits);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, outcome_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
